[hw/rtl/pugp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise uniform grid point package
// Command and status codes, datapath widths and the segment table entry.
// ----------------------------------------------------------------------------
package pugp_pkg;

    localparam int DATA_W     = 64;
    localparam int INDEX_W    = 32;
    localparam int DIVIDEND_W = DATA_W + INDEX_W;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_ZERO_STEP = 2'd2;

    localparam logic [DATA_W-1:0] VALUE_PAST_END = 64'h7FFF_FFFF_FFFF_FFFF;

    // One stored segment: ordered left bound, width and rounded step count.
    typedef struct packed {
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] width;
        logic [DATA_W-1:0] steps;
    } seg_entry_t;

endpackage

[hw/rtl/piecewise_uniform_grid_point.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise uniform grid point table
// Segment table with append, clear and grid point lookup by index.
// ----------------------------------------------------------------------------
// Clear and unused commands go straight to the finish state. Append runs
// the shared divider over the segment width and step, with rounding.
// Query reads and checks each segment walked in turn, then multiplies,
// adds and runs the divider; one item is in work at a time.
// Reset clears the segment count, the running point total and all control;
// the segment memory itself is not cleared and is read only below the count.
module piecewise_uniform_grid_point
#(
    parameter int MAX_SEGMENTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic signed [63:0]    seg_left,
    input  logic signed [63:0]    seg_right,
    input  logic signed [63:0]    seg_step,
    input  logic [31:0]           point_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [63:0]    point_value,
    output logic                  out_of_range,
    output logic [31:0]           total_points,
    output logic [1:0]            status
);

    localparam int DW     = pugp_pkg::DATA_W;
    localparam int IW     = pugp_pkg::INDEX_W;
    localparam int NW     = pugp_pkg::DIVIDEND_W;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    // Exact point total: each segment adds at most 2^64 points.
    localparam int SUM_W  = DW + CNT_W + 1;

    // Sequencer states. The divider is shared by append (step count) and
    // query (interpolation); one 32x32 multiplier forms the product in halves.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DIV_A  = 9'b000000010,
        ST_READ   = 9'b000000100,
        ST_WALK   = 9'b000001000,
        ST_MUL0   = 9'b000010000,
        ST_MUL1   = 9'b000100000,
        ST_ADD    = 9'b001000000,
        ST_DIV_Q  = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [SUM_W-1:0]      acc_reg, acc_next;
    logic [IW-1:0]         index_reg, index_next;
    logic [IW-1:0]         off_reg, off_next;
    logic [DW-1:0]         left_reg, left_next;
    logic [DW-1:0]         width_reg, width_next;
    logic [DW-1:0]         q_reg, q_next;
    logic [DW-1:0]         right_reg, right_next;
    logic [DW-1:0]         last_right_reg, last_right_next;
    logic                  joins_reg, joins_next;
    logic [DW-1:0]         p0_reg, p0_next;
    logic [DW-1:0]         p1_reg, p1_next;
    logic [DW-1:0]         val_reg, val_next;
    logic                  oor_reg, oor_next;
    logic [1:0]            stat_reg, stat_next;
    logic                  ovalid_reg, ovalid_next;
    logic [DW-1:0]         ovalue_reg, ovalue_next;
    logic                  ooor_reg, ooor_next;
    logic [31:0]           ototal_reg, ototal_next;
    logic [1:0]            ostat_reg, ostat_next;

    // Segment memory and the per-entry flag saying the entry starts where
    // the one before it ends.
    pugp_pkg::seg_entry_t  seg_mem [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] joins_vec;
    pugp_pkg::seg_entry_t  rd_reg;
    logic                  mem_we;

    logic                  accept;
    logic [DW-1:0]         step_mag;
    logic                  swap;
    logic [DW-1:0]         left_ord;
    logic [DW-1:0]         right_ord;
    logic [CNT_W-1:0]      j_plus;
    logic                  closed;
    logic [SUM_W-1:0]      walk_sum;
    logic [DW-1:0]         mul_res;
    logic                  div_start;
    logic [NW-1:0]         div_dividend;
    logic [DW-1:0]         div_divisor;
    logic                  div_done;
    logic [DW-1:0]         div_quo;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    assign step_mag  = seg_step[DW-1] ? (~seg_step + 1'b1) : seg_step;
    assign swap      = seg_right < seg_left;
    assign left_ord  = swap ? seg_right : seg_left;
    assign right_ord = swap ? seg_left : seg_right;

    // A segment carries a closing point when it is the last one or the next
    // segment does not start at its right bound.
    assign j_plus    = j_reg + 1'b1;
    assign closed    = (j_plus >= used_reg) || !joins_vec[j_plus[IDX_W-1:0]];
    assign walk_sum  = acc_reg + SUM_W'(rd_reg.steps) + SUM_W'(closed);

    // Shared 32x32 multiplier: low then high half of the segment width.
    assign mul_res   = DW'(off_reg) *
                       DW'((state_reg == ST_MUL0) ? width_reg[31:0] : width_reg[63:32]);

    assign div_dividend = (state_reg == ST_ADD)
                        ? ({32'd0, p0_reg} + {p1_reg, 32'd0})
                        : {32'd0, right_ord - left_ord};
    assign div_divisor  = (state_reg == ST_ADD) ? q_reg : step_mag;

    assign mem_we = (state_reg == ST_DIV_A) && div_done;

    pugp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        sum_next        = sum_reg;
        j_next          = j_reg;
        acc_next        = acc_reg;
        index_next      = index_reg;
        off_next        = off_reg;
        left_next       = left_reg;
        width_next      = width_reg;
        q_next          = q_reg;
        right_next      = right_reg;
        last_right_next = last_right_reg;
        joins_next      = joins_reg;
        p0_next         = p0_reg;
        p1_next         = p1_reg;
        val_next        = val_reg;
        oor_next        = oor_reg;
        stat_next       = stat_reg;
        ovalid_next     = ovalid_reg && !out_ready;
        ovalue_next     = ovalue_reg;
        ooor_next       = ooor_reg;
        ototal_next     = ototal_reg;
        ostat_next      = ostat_reg;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next   = '0;
                    oor_next   = 1'b0;
                    stat_next  = pugp_pkg::STATUS_OK;
                    index_next = point_index;
                    state_next = ST_FINISH;
                    unique case (cmd)
                        pugp_pkg::CMD_CLEAR:
                        begin
                            used_next = '0;
                            sum_next  = '0;
                        end
                        pugp_pkg::CMD_APPEND:
                        begin
                            if (used_reg >= CNT_W'(MAX_SEGMENTS))
                            begin
                                stat_next = pugp_pkg::STATUS_FULL;
                            end
                            else if (step_mag == '0)
                            begin
                                stat_next = pugp_pkg::STATUS_ZERO_STEP;
                            end
                            else
                            begin
                                left_next  = left_ord;
                                width_next = right_ord - left_ord;
                                right_next = right_ord;
                                joins_next = (used_reg != '0) && (left_ord == last_right_reg);
                                div_start  = 1'b1;
                                state_next = ST_DIV_A;
                            end
                        end
                        pugp_pkg::CMD_QUERY:
                        begin
                            if (used_reg == '0)
                            begin
                                val_next = pugp_pkg::VALUE_PAST_END;
                                oor_next = 1'b1;
                            end
                            else
                            begin
                                j_next     = '0;
                                acc_next   = '0;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            val_next = '0;
                        end
                    endcase
                end
            end
            ST_DIV_A:
            begin
                if (div_done)
                begin
                    // The old last segment loses its closing point when the
                    // new one joins it; the new one brings steps plus one.
                    sum_next        = sum_reg + SUM_W'(div_quo) + SUM_W'(!joins_reg);
                    used_next       = used_reg + 1'b1;
                    last_right_next = right_reg;
                    state_next      = ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if ({{(SUM_W-IW){1'b0}}, index_reg} < walk_sum)
                begin
                    off_next  = index_reg - acc_reg[IW-1:0];
                    left_next = rd_reg.left;
                    width_next = rd_reg.width;
                    q_next    = rd_reg.steps;
                    if (rd_reg.steps == '0)
                    begin
                        val_next   = rd_reg.left;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_MUL0;
                    end
                end
                else
                begin
                    acc_next = walk_sum;
                    j_next   = j_plus;
                    if (j_plus == used_reg)
                    begin
                        val_next   = pugp_pkg::VALUE_PAST_END;
                        oor_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_MUL0:
            begin
                p0_next    = mul_res;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                p1_next    = mul_res;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_Q;
            end
            ST_DIV_Q:
            begin
                if (div_done)
                begin
                    val_next   = left_reg + div_quo;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    ovalue_next = val_reg;
                    ooor_next   = oor_reg;
                    ototal_next = (|sum_reg[SUM_W-1:32]) ? 32'hFFFF_FFFF : sum_reg[31:0];
                    ostat_next  = stat_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            used_reg   <= '0;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            sum_reg    <= sum_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg          <= j_next;
        acc_reg        <= acc_next;
        index_reg      <= index_next;
        off_reg        <= off_next;
        left_reg       <= left_next;
        width_reg      <= width_next;
        q_reg          <= q_next;
        right_reg      <= right_next;
        last_right_reg <= last_right_next;
        joins_reg      <= joins_next;
        p0_reg         <= p0_next;
        p1_reg         <= p1_next;
        val_reg        <= val_next;
        oor_reg        <= oor_next;
        stat_reg       <= stat_next;
        ovalue_reg     <= ovalue_next;
        ooor_reg       <= ooor_next;
        ototal_reg     <= ototal_next;
        ostat_reg      <= ostat_next;
    end

    // Segment memory: one write port at the append slot, one registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem[used_reg[IDX_W-1:0]]   <= '{left: left_reg, width: width_reg, steps: div_quo};
            joins_vec[used_reg[IDX_W-1:0]] <= joins_reg;
        end
        rd_reg <= seg_mem[j_reg[IDX_W-1:0]];
    end

    assign out_valid    = ovalid_reg;
    assign point_value  = ovalue_reg;
    assign out_of_range = ooor_reg;
    assign total_points = ototal_reg;
    assign status       = ostat_reg;

    a_used_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count exceeds table depth");

    a_nonempty_has_points : assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != '0 |-> sum_reg != '0)
        else $error("table holds segments but point total is zero");

    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == pugp_pkg::CMD_CLEAR |=> used_reg == '0 && sum_reg == '0)
        else $error("clear did not empty the table");

    a_div_done_expected : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_A || state_reg == ST_DIV_Q)
        else $error("divider finished while the sequencer was not waiting");

    a_walk_in_table : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> j_reg < used_reg)
        else $error("query walk beyond the last segment");

endmodule

[hw/rtl/pugp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise uniform grid point divider
// Restoring divider, one quotient bit per cycle, result rounded half up.
// ----------------------------------------------------------------------------
module pugp_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pugp_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [pugp_pkg::DATA_W-1:0]         divisor,
    output logic                                done,
    output logic [pugp_pkg::DATA_W-1:0]         quotient
);

    localparam int DW  = pugp_pkg::DATA_W;
    localparam int NW  = pugp_pkg::DIVIDEND_W;
    localparam int CW  = $clog2(NW);

    logic          run_reg, run_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [DW-1:0] res_reg, res_next;
    logic [DW:0]   rem_ext;
    logic [DW:0]   rem_sub;
    logic          take;

    assign rem_ext = {rem_reg, num_reg[NW-1]};
    assign rem_sub = rem_ext - {1'b0, dsr_reg};
    assign take    = rem_ext >= {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        res_next  = res_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(NW - 1);
            num_next = dividend;
            rem_next = '0;
            quo_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            rem_next = take ? rem_sub[DW-1:0] : rem_ext[DW-1:0];
            quo_next = {quo_reg[DW-2:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            // Round half up: bump when the remainder is at least half the divisor.
            res_next  = quo_reg + DW'(rem_reg >= (dsr_reg - rem_reg));
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        res_reg <= res_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

    a_done_after_round : assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg && !start |=> done_reg)
        else $error("divider finished without reporting done");

    a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !fin_reg)
        else $error("divider iterating and rounding at once");

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule
